>>> hw/rtl/ccbd_pkg.sv
// Shared types and constants for the CPU bus decoder.
// Holds the memory map bounds, target codes and the decode struct.
// No dependencies.
`timescale 1ns / 1ps

package ccbd_pkg;

  localparam int WORK_RAM_DEPTH_DEF = 2048;
  localparam int SAVE_RAM_DEPTH_DEF = 8192;

  localparam logic [15:0] WORK_RAM_LAST = 16'h1FFF;
  localparam logic [15:0] PPU_LAST      = 16'h3FFF;
  localparam logic [15:0] OAM_DMA_ADDR  = 16'h4014;
  localparam logic [15:0] APU_STATUS    = 16'h4015;
  localparam logic [15:0] PAD_ZERO_PORT = 16'h4016;
  localparam logic [15:0] PAD_ONE_PORT  = 16'h4017;
  localparam logic [15:0] IO_LAST       = 16'h401F;
  localparam logic [15:0] EXP_LAST      = 16'h5FFF;
  localparam logic [15:0] SAVE_LAST     = 16'h7FFF;

  localparam logic [2:0] PPU_INDEX_MASK = 3'h7;

  typedef enum logic [2:0] {
    TGT_WORK = 3'd0,
    TGT_PPU  = 3'd1,
    TGT_APU  = 3'd2,
    TGT_PAD  = 3'd3,
    TGT_DMA  = 3'd4,
    TGT_NONE = 3'd5,
    TGT_SAVE = 3'd6,
    TGT_CART = 3'd7
  } target_t;

  // Decoded request: where it goes and which local resources it touches.
  typedef struct packed {
    target_t     target;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;
    logic        work_en;
    logic        save_en;
    logic        wr;
    logic        pad_wr;
    logic        pad_rd0;
    logic        pad_rd1;
  } dec_t;

endpackage

>>> hw/rtl/ccbd_ram.sv
// Generic single-port RAM with registered read and read enable.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module ccbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hw/rtl/ccbd_decode.sv
// Address decoder: maps one bus request onto the standard memory map.
// Depends on ccbd_pkg.
`timescale 1ns / 1ps

module ccbd_decode (
  input  logic          wr,
  input  logic [15:0]   addr,
  input  logic [7:0]    wdata,
  output ccbd_pkg::dec_t dec
);

  always_comb begin
    dec          = '0;
    dec.target   = ccbd_pkg::TGT_NONE;
    dec.wr       = wr;
    if (addr <= ccbd_pkg::WORK_RAM_LAST) begin
      dec.target  = ccbd_pkg::TGT_WORK;
      dec.work_en = 1'b1;
    end else if (addr <= ccbd_pkg::PPU_LAST) begin
      dec.target   = ccbd_pkg::TGT_PPU;
      dec.fwd_addr = {13'd0, addr[2:0] & ccbd_pkg::PPU_INDEX_MASK};
      dec.fwd_data = wr ? wdata : 8'd0;
    end else if (addr <= ccbd_pkg::IO_LAST) begin
      if (wr) begin
        if (addr == ccbd_pkg::OAM_DMA_ADDR) begin
          dec.target   = ccbd_pkg::TGT_DMA;
          dec.fwd_data = wdata;
        end else if (addr == ccbd_pkg::PAD_ZERO_PORT) begin
          dec.target = ccbd_pkg::TGT_PAD;
          dec.pad_wr = 1'b1;
        end else begin
          dec.target   = ccbd_pkg::TGT_APU;
          dec.fwd_addr = addr;
          dec.fwd_data = wdata;
        end
      end else begin
        if (addr == ccbd_pkg::APU_STATUS) begin
          dec.target   = ccbd_pkg::TGT_APU;
          dec.fwd_addr = addr;
        end else if (addr == ccbd_pkg::PAD_ZERO_PORT) begin
          dec.target  = ccbd_pkg::TGT_PAD;
          dec.pad_rd0 = 1'b1;
        end else if (addr == ccbd_pkg::PAD_ONE_PORT) begin
          dec.target  = ccbd_pkg::TGT_PAD;
          dec.pad_rd1 = 1'b1;
        end else begin
          dec.target = ccbd_pkg::TGT_NONE;
        end
      end
    end else if (addr <= ccbd_pkg::EXP_LAST) begin
      dec.target = ccbd_pkg::TGT_NONE;
    end else if (addr <= ccbd_pkg::SAVE_LAST) begin
      dec.target  = ccbd_pkg::TGT_SAVE;
      dec.save_en = 1'b1;
    end else begin
      dec.target   = ccbd_pkg::TGT_CART;
      dec.fwd_addr = addr;
      dec.fwd_data = wr ? wdata : 8'd0;
    end
  end

endmodule

>>> hw/rtl/ccbd_pad.sv
// Pad port logic: strobe register and the two button shift registers.
// Depends on ccbd_pkg for the decode struct.
`timescale 1ns / 1ps

module ccbd_pad (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  ccbd_pkg::dec_t dec,
  input  logic [7:0]     wdata,
  input  logic [7:0]     buttons0,
  input  logic [7:0]     buttons1,
  output logic [7:0]     rd_data
);

  logic       strobe_r, strobe_nxt;
  logic [7:0] shift0_r, shift0_nxt;
  logic [7:0] shift1_r, shift1_nxt;

  always_comb begin
    strobe_nxt = strobe_r;
    shift0_nxt = shift0_r;
    shift1_nxt = shift1_r;
    rd_data    = 8'd0;
    if (dec.pad_rd0) begin
      rd_data = {7'd0, strobe_r ? buttons0[0] : shift0_r[0]};
    end else if (dec.pad_rd1) begin
      rd_data = {7'd0, strobe_r ? buttons1[0] : shift1_r[0]};
    end
    if (accept) begin
      if (dec.pad_wr) begin
        strobe_nxt = wdata[0];
        // latch buttons on the falling strobe
        if (strobe_r && !wdata[0]) begin
          shift0_nxt = buttons0;
          shift1_nxt = buttons1;
        end
      end
      if (dec.pad_rd0 && !strobe_r) begin
        shift0_nxt = {1'b0, shift0_r[7:1]};
      end
      if (dec.pad_rd1 && !strobe_r) begin
        shift1_nxt = {1'b0, shift1_r[7:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      shift0_r <= 8'd0;
      shift1_r <= 8'd0;
    end else begin
      strobe_r <= strobe_nxt;
      shift0_r <= shift0_nxt;
      shift1_r <= shift1_nxt;
    end
  end

endmodule

>>> hw/rtl/console_cpu_bus_decoder_top.sv
// CPU bus decoder top: one bus request per cycle while no clearing pass runs and the output is not stalled.
// A request passes the RAM read stage (stage 1), then the output register.
// Throughput: one request per clock when not stalled, set by the single port of each RAM.
// Reset: pad state clears at once; a clearing pass then zeroes both RAMs,
// up to the larger of the two depths, with in_tready low.
// Depends on ccbd_pkg, ccbd_ram, ccbd_decode, ccbd_pad.
`timescale 1ns / 1ps

module console_cpu_bus_decoder_top #(
  parameter int WORK_RAM_DEPTH = ccbd_pkg::WORK_RAM_DEPTH_DEF,
  parameter int SAVE_RAM_DEPTH = ccbd_pkg::SAVE_RAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[15:0], write_data[23:16], pad_zero_buttons[31:24], pad_one_buttons[39:32]
  input  logic [39:0] in_tdata,
  // action[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], forward_address[23:8], forward_data[31:24]
  output logic [31:0] out_tdata,
  // target[2:0]
  output logic [2:0]  out_tuser
);

  localparam int WAW = $clog2(WORK_RAM_DEPTH);
  localparam int SAW = $clog2(SAVE_RAM_DEPTH);
  localparam int CLR_DEPTH = (WORK_RAM_DEPTH > SAVE_RAM_DEPTH) ? WORK_RAM_DEPTH
                                                                : SAVE_RAM_DEPTH;
  localparam int CW = $clog2(CLR_DEPTH);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_DEPTH - 1);

  logic        in_wr;
  logic [15:0] in_addr;
  logic [7:0]  in_wdata, in_btn0, in_btn1;
  assign in_wr    = in_tuser[0];
  assign in_addr  = in_tdata[15:0];
  assign in_wdata = in_tdata[23:16];
  assign in_btn0  = in_tdata[31:24];
  assign in_btn1  = in_tdata[39:32];

  // clearing pass
  logic          clr_busy_r, clr_busy_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + CW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // pipeline control
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic s1_adv, accept;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_v_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  ccbd_pkg::dec_t dec;
  logic [7:0]     pad_rd;

  ccbd_decode u_decode (
    .wr    (in_wr),
    .addr  (in_addr),
    .wdata (in_wdata),
    .dec   (dec)
  );

  ccbd_pad u_pad (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .dec      (dec),
    .wdata    (in_wdata),
    .buttons0 (in_btn0),
    .buttons1 (in_btn1),
    .rd_data  (pad_rd)
  );

  // RAM ports: clearing pass or the accepted request
  logic           work_en, work_we, save_en, save_we;
  logic [WAW-1:0] work_addr;
  logic [SAW-1:0] save_addr;
  logic [7:0]     ram_wdata, work_rdata, save_rdata;

  always_comb begin
    if (clr_busy_r) begin
      work_en   = 1'b1;
      work_we   = 1'b1;
      save_en   = 1'b1;
      save_we   = 1'b1;
      work_addr = clr_cnt_r[WAW-1:0];
      save_addr = clr_cnt_r[SAW-1:0];
      ram_wdata = 8'd0;
    end else begin
      work_en   = accept && dec.work_en;
      work_we   = dec.wr;
      save_en   = accept && dec.save_en;
      save_we   = dec.wr;
      work_addr = in_addr[WAW-1:0];
      // save window base is a multiple of the depth, so the low bits index it
      save_addr = in_addr[SAW-1:0];
      ram_wdata = in_wdata;
    end
  end

  ccbd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_DEPTH)) u_work_ram (
    .clk   (clk),
    .en    (work_en),
    .we    (work_we),
    .addr  (work_addr),
    .wdata (ram_wdata),
    .rdata (work_rdata)
  );

  ccbd_ram #(.WIDTH(8), .DEPTH(SAVE_RAM_DEPTH)) u_save_ram (
    .clk   (clk),
    .en    (save_en),
    .we    (save_we),
    .addr  (save_addr),
    .wdata (ram_wdata),
    .rdata (save_rdata)
  );

  // stage 1: waits on the RAM read
  ccbd_pkg::target_t s1_tgt_r;
  logic [15:0]       s1_faddr_r;
  logic [7:0]        s1_fdata_r, s1_rd_r;
  logic              s1_work_rd_r, s1_save_rd_r;
  logic [7:0]        s1_rdata;

  ccbd_pkg::target_t out_tgt_r;
  logic [15:0]       out_faddr_r;
  logic [7:0]        out_fdata_r, out_rd_r;

  assign s1_v_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? 1'b1 : ((out_v_r && out_tready) ? 1'b0 : out_v_r);

  always_comb begin
    if (s1_work_rd_r) begin
      s1_rdata = work_rdata;
    end else if (s1_save_rd_r) begin
      s1_rdata = save_rdata;
    end else begin
      s1_rdata = s1_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tgt_r     <= dec.target;
      s1_faddr_r   <= dec.fwd_addr;
      s1_fdata_r   <= dec.fwd_data;
      s1_rd_r      <= pad_rd;
      s1_work_rd_r <= dec.work_en && !dec.wr;
      s1_save_rd_r <= dec.save_en && !dec.wr;
    end
    if (s1_adv) begin
      out_tgt_r   <= s1_tgt_r;
      out_faddr_r <= s1_faddr_r;
      out_fdata_r <= s1_fdata_r;
      out_rd_r    <= s1_rdata;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_fdata_r, out_faddr_r, out_rd_r};
  assign out_tuser  = out_tgt_r;

endmodule

>>> test/tb.sv
// Testbench for console_cpu_bus_decoder_top: drives CPU bus requests, predicts each decode.
// Walks a directed table first, then random bursts (pad strobe and read-out, RAM write/read, single accesses).
// Depends on ccbd_pkg and the RTL of console_cpu_bus_decoder_top.
`timescale 1ns / 1ps

module tb;
  import ccbd_pkg::*;

  localparam int IDLE_LIMIT = 30000;
  localparam int PHASE_ITEMS = 633;

  typedef struct {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  btn0;
    logic [7:0]  btn1;
  } bus_access_t;

  typedef struct {
    logic [7:0]  rdata;
    target_t     tgt;
    logic [15:0] faddr;
    logic [7:0]  fdata;
  } bus_decode_t;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  btn0;
    logic [7:0]  btn1;
    logic        typed;
    logic [7:0]  rdata;
    target_t     tgt;
    logic [15:0] faddr;
    logic [7:0]  fdata;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  // predicted state of the block
  logic [7:0] work_mem [WORK_RAM_DEPTH_DEF];
  logic [7:0] save_mem [SAVE_RAM_DEPTH_DEF];
  logic       strobe;
  logic [7:0] pad0_sr;
  logic [7:0] pad1_sr;

  bus_decode_t expected_decodes [$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          send_idle = 35;
  int          recv_idle = 75;

  stim_row_t directed_rows [27] = '{
    '{1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_WORK, 16'h0000, 8'h00},
    '{1'b0, 16'h7FFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_SAVE, 16'h0000, 8'h00},
    '{1'b0, 16'h4016, 8'h00, 8'hFF, 8'hFF, 1'b1, 8'h00, TGT_PAD,  16'h0000, 8'h00},
    '{1'b1, 16'h0000, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, TGT_WORK, 16'h0000, 8'h00},
    '{1'b0, 16'h1800, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_WORK, 16'h0000, 8'h00},
    '{1'b1, 16'h07FF, 8'hA5, 8'h00, 8'h00, 1'b1, 8'h00, TGT_WORK, 16'h0000, 8'h00},
    '{1'b0, 16'h1FFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hA5, TGT_WORK, 16'h0000, 8'h00},
    '{1'b1, 16'h6000, 8'h5A, 8'h00, 8'h00, 1'b1, 8'h00, TGT_SAVE, 16'h0000, 8'h00},
    '{1'b0, 16'h6000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h5A, TGT_SAVE, 16'h0000, 8'h00},
    '{1'b1, 16'h2000, 8'h12, 8'h00, 8'h00, 1'b1, 8'h00, TGT_PPU,  16'h0000, 8'h12},
    '{1'b0, 16'h3FFF, 8'hEE, 8'h00, 8'h00, 1'b1, 8'h00, TGT_PPU,  16'h0007, 8'h00},
    '{1'b1, 16'h4014, 8'hC3, 8'h00, 8'h00, 1'b1, 8'h00, TGT_DMA,  16'h0000, 8'hC3},
    '{1'b0, 16'h4014, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_NONE, 16'h0000, 8'h00},
    '{1'b0, 16'h4015, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_APU,  16'h4015, 8'h00},
    '{1'b1, 16'h4017, 8'h40, 8'h00, 8'h00, 1'b1, 8'h00, TGT_APU,  16'h4017, 8'h40},
    '{1'b1, 16'h401F, 8'h77, 8'h00, 8'h00, 1'b1, 8'h00, TGT_APU,  16'h401F, 8'h77},
    '{1'b0, 16'h4000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_NONE, 16'h0000, 8'h00},
    // strobe high: reads return the live A bit
    '{1'b1, 16'h4016, 8'h01, 8'h81, 8'h00, 1'b1, 8'h00, TGT_PAD,  16'h0000, 8'h00},
    '{1'b0, 16'h4016, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h01, TGT_PAD,  16'h0000, 8'h00},
    '{1'b0, 16'h4017, 8'h00, 8'h00, 8'hFE, 1'b1, 8'h00, TGT_PAD,  16'h0000, 8'h00},
    // strobe falls: latch buttons, then shift out
    '{1'b1, 16'h4016, 8'hFE, 8'h81, 8'h7E, 1'b1, 8'h00, TGT_PAD,  16'h0000, 8'h00},
    '{1'b0, 16'h4016, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, TGT_WORK, 16'h0000, 8'h00},
    '{1'b0, 16'h4017, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, TGT_WORK, 16'h0000, 8'h00},
    '{1'b1, 16'h4020, 8'h99, 8'h00, 8'h00, 1'b1, 8'h00, TGT_NONE, 16'h0000, 8'h00},
    '{1'b0, 16'h5FFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_NONE, 16'h0000, 8'h00},
    '{1'b1, 16'h8000, 8'h3C, 8'h00, 8'h00, 1'b1, 8'h00, TGT_CART, 16'h8000, 8'h3C},
    '{1'b0, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_CART, 16'hFFFF, 8'h00}
  };

  console_cpu_bus_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] shift_pad(inout logic [7:0] sr, input logic [7:0] btn);
    logic [7:0] bit0;
    if (strobe) begin
      return {7'd0, btn[0]};
    end
    bit0 = {7'd0, sr[0]};
    sr = sr >> 1;
    return bit0;
  endfunction

  function automatic bus_decode_t decode_access(bus_access_t a);
    bus_decode_t r;
    int          save_idx;
    r = '{8'h00, TGT_NONE, 16'h0000, 8'h00};
    if (a.addr <= WORK_RAM_LAST) begin
      r.tgt = TGT_WORK;
      if (a.wr) work_mem[a.addr % WORK_RAM_DEPTH_DEF] = a.wdata;
      else r.rdata = work_mem[a.addr % WORK_RAM_DEPTH_DEF];
    end else if (a.addr <= PPU_LAST) begin
      r.tgt = TGT_PPU;
      r.faddr = {13'd0, a.addr[2:0] & PPU_INDEX_MASK};
      if (a.wr) r.fdata = a.wdata;
    end else if (a.addr <= IO_LAST) begin
      if (a.wr) begin
        if (a.addr == OAM_DMA_ADDR) begin
          r.tgt = TGT_DMA;
          r.fdata = a.wdata;
        end else if (a.addr == PAD_ZERO_PORT) begin
          r.tgt = TGT_PAD;
          if (strobe && !a.wdata[0]) begin
            pad0_sr = a.btn0;
            pad1_sr = a.btn1;
          end
          strobe = a.wdata[0];
        end else begin
          r.tgt = TGT_APU;
          r.faddr = a.addr;
          r.fdata = a.wdata;
        end
      end else if (a.addr == APU_STATUS) begin
        r.tgt = TGT_APU;
        r.faddr = a.addr;
      end else if (a.addr == PAD_ZERO_PORT) begin
        r.tgt = TGT_PAD;
        r.rdata = shift_pad(pad0_sr, a.btn0);
      end else if (a.addr == PAD_ONE_PORT) begin
        r.tgt = TGT_PAD;
        r.rdata = shift_pad(pad1_sr, a.btn1);
      end
    end else if (a.addr <= EXP_LAST) begin
      r.tgt = TGT_NONE;
    end else if (a.addr <= SAVE_LAST) begin
      r.tgt = TGT_SAVE;
      save_idx = (int'(a.addr) - int'(EXP_LAST) - 1) % SAVE_RAM_DEPTH_DEF;
      if (a.wr) save_mem[save_idx] = a.wdata;
      else r.rdata = save_mem[save_idx];
    end else begin
      r.tgt = TGT_CART;
      r.faddr = a.addr;
      if (a.wr) r.fdata = a.wdata;
    end
    return r;
  endfunction

  // Present one request, hold it until accepted, then queue its predicted decode, or the given one for a typed row.
  task automatic drive_request(bus_access_t a, bit typed, bus_decode_t typed_res);
    bus_decode_t pred;
    logic        ready_seen;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {a.btn1, a.btn0, a.wdata, a.addr};
    in_tuser  <= a.wr;
    forever begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
      if (ready_seen) break;
    end
    pred = decode_access(a);
    expected_decodes.push_back(typed ? typed_res : pred);
    requests_sent++;
  endtask

  function automatic bus_access_t make_access(logic wr, logic [15:0] addr, logic [7:0] data);
    bus_access_t a;
    a.wr    = wr;
    a.addr  = addr;
    a.wdata = data;
    a.btn0  = 8'($urandom);
    a.btn1  = 8'($urandom);
    return a;
  endfunction

  task automatic send_random(bus_access_t a);
    drive_request(a, 1'b0, '{8'h00, TGT_NONE, 16'h0000, 8'h00});
  endtask

  task automatic random_burst();
    int          kind;
    int          n;
    logic [15:0] addr;
    logic [15:0] alias_addr;
    logic [15:0] port;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // strobe pulse, then shift out a random number of bits
      send_random(make_access(1'b1, PAD_ZERO_PORT, 8'($urandom) | 8'h01));
      n = $urandom_range(0, 2);
      repeat (n) begin
        port = $urandom_range(0, 1) ? PAD_ONE_PORT : PAD_ZERO_PORT;
        send_random(make_access(1'b0, port, 8'($urandom)));
      end
      send_random(make_access(1'b1, PAD_ZERO_PORT, 8'($urandom) & 8'hFE));
      n = $urandom_range(1, 10);
      repeat (n) begin
        port = $urandom_range(0, 1) ? PAD_ONE_PORT : PAD_ZERO_PORT;
        send_random(make_access(1'b0, port, 8'($urandom)));
      end
    end else if (kind < 55) begin
      // write, then read back after up to two random accesses, through a mirror for work RAM
      if ($urandom_range(0, 1)) begin
        addr = 16'($urandom_range(0, 16'h1FFF));
        alias_addr = {3'b000, 2'($urandom), addr[10:0]};
      end else begin
        addr = 16'($urandom_range(16'h6000, 16'h7FFF));
        alias_addr = addr;
      end
      send_random(make_access(1'b1, addr, 8'($urandom)));
      n = $urandom_range(0, 2);
      repeat (n) send_random(make_access(1'($urandom), 16'($urandom), 8'($urandom)));
      send_random(make_access(1'b0, alias_addr, 8'($urandom)));
    end else begin
      case ($urandom_range(0, 6))
        0: addr = 16'($urandom_range(16'h0000, 16'h1FFF));
        1: addr = 16'($urandom_range(16'h2000, 16'h3FFF));
        2: addr = 16'($urandom_range(16'h4000, 16'h401F));
        3: addr = 16'($urandom_range(16'h4020, 16'h5FFF));
        4: addr = 16'($urandom_range(16'h6000, 16'h7FFF));
        5: addr = 16'($urandom_range(16'h8000, 16'hFFFF));
        default: addr = 16'($urandom);
      endcase
      send_random(make_access(1'($urandom), addr, 8'($urandom)));
    end
  endtask

  always @(posedge clk) begin
    out_tready <= (recv_idle == 0) || ($urandom_range(0, 99) >= recv_idle);
  end

  // Sample at the falling edge: a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    bus_decode_t exp_res;
    bus_decode_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.rdata = out_tdata[7:0];
      got.faddr = out_tdata[23:8];
      got.fdata = out_tdata[31:24];
      got.tgt   = target_t'(out_tuser);
      if (expected_decodes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: rd=%h tgt=%0d fa=%h fd=%h",
                   got.rdata, got.tgt, got.faddr, got.fdata);
        mismatches++;
      end else begin
        exp_res = expected_decodes.pop_front();
        if (got.rdata !== exp_res.rdata || got.tgt !== exp_res.tgt ||
            got.faddr !== exp_res.faddr || got.fdata !== exp_res.fdata) begin
          if (mismatches < 10)
            $display("mismatch: expected rd=%h tgt=%0d fa=%h fd=%h, got rd=%h tgt=%0d fa=%h fd=%h",
                     exp_res.rdata, exp_res.tgt, exp_res.faddr, exp_res.fdata,
                     got.rdata, got.tgt, got.faddr, got.fdata);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    bus_access_t acc;
    bus_decode_t row_res;
    int          phase;
    int          goal;
    foreach (work_mem[i]) work_mem[i] = 8'h00;
    foreach (save_mem[i]) save_mem[i] = 8'h00;
    strobe  = 1'b0;
    pad0_sr = 8'h00;
    pad1_sr = 8'h00;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      acc = '{directed_rows[i].wr, directed_rows[i].addr, directed_rows[i].wdata,
              directed_rows[i].btn0, directed_rows[i].btn1};
      row_res = '{directed_rows[i].rdata, directed_rows[i].tgt,
                  directed_rows[i].faddr, directed_rows[i].fdata};
      drive_request(acc, directed_rows[i].typed, row_res);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 35; recv_idle = 75; end
        1: begin send_idle = 75; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      goal = requests_sent + PHASE_ITEMS;
      while (requests_sent < goal) random_burst();
      // drain before the next idling pattern
      in_tvalid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_decodes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
